// File: design/mtacc_pkg.sv
// Shared constants and types for the 4x4 outer-product tile accumulator.
`timescale 1ns / 1ps

package mtacc_pkg;

    localparam int TILE       = 4;
    localparam int LANES      = TILE * TILE;
    localparam int IDX_W      = $clog2(LANES);
    localparam int POS_W      = $clog2(TILE);
    localparam int FIELD_W    = 16;
    localparam int DATA_WIDTH = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int ACC_W      = 48;
    localparam int MAX_DEPTH  = 4096;
    localparam int CNT_W      = $clog2(MAX_DEPTH + 1);
    localparam int IN_W       = 2 * TILE * FIELD_W;
    localparam int OUT_RAW_W  = 2 * POS_W + ACC_W;
    localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;

    typedef logic signed [DATA_WIDTH-1:0] elem_t;
    typedef logic signed [ACC_W-1:0] acc_t;

endpackage

// File: design/mtacc_lane.sv
// One multiply-accumulate lane: registered product and saturating 48-bit accumulator.
`timescale 1ns / 1ps

module mtacc_lane (
    input  logic             clk,
    input  logic             rst_n,
    input  mtacc_pkg::elem_t a,
    input  mtacc_pkg::elem_t b,
    input  logic             load,
    input  logic             accum,
    input  logic             clear,
    output mtacc_pkg::acc_t  sum
);
    import mtacc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    acc_t                     acc_reg;
    acc_t                     acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W:0]    wide;

    always_comb
    begin
        prod_ext = ACC_W'(prod_reg);
        wide     = {acc_reg[ACC_W-1], acc_reg} + {prod_ext[ACC_W-1], prod_ext};
        if (wide[ACC_W] != wide[ACC_W-1])
        begin
            sum = wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sum = wide[ACC_W-1:0];
        end
        acc_next = clear ? '0 : sum;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= a * b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (accum)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// File: design/mtacc_drain.sv
// Output bank that holds a finished tile and sends its sixteen sums in row-major order.
`timescale 1ns / 1ps

module mtacc_drain (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          capture,
    input  mtacc_pkg::acc_t               sums [mtacc_pkg::LANES],
    output logic                          bank_free,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mtacc_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                          m_axis_tlast
);
    import mtacc_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LANES - 1);

    acc_t             bank_reg [LANES];
    logic             valid_reg;
    logic             valid_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_fire;

    always_comb
    begin
        out_fire  = valid_reg && m_axis_tready;
        bank_free = !valid_reg || (out_fire && idx_reg == LAST_IDX);
        idx_next  = idx_reg;
        valid_next = valid_reg;
        if (out_fire)
        begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg == LAST_IDX)
            begin
                valid_next = 1'b0;
            end
        end
        if (capture)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                bank_reg[i] <= sums[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = (idx_reg == LAST_IDX);
    assign m_axis_tdata  = OUT_W'({bank_reg[idx_reg], idx_reg[POS_W-1:0],
                                   idx_reg[IDX_W-1:POS_W]});

endmodule

// File: design/matmul_tile_4x4_accumulator.sv
// Top level of the 4x4 outer-product matrix tile accumulator.
// Usage:
// Each input word on s_axis is one step along the shared dimension: four A tile
// column elements and four B tile row elements, signed Q8.8, with tlast marking
// the last step of the tile. Sixteen lanes each register one product and add it
// into a saturating 48-bit accumulator; one word is taken every cycle unless stalled.
// After the last step, or after MAX_DEPTH steps, the sixteen sums move into an
// output bank and the accumulators clear in the same cycle. The bank sends one
// sum per word on m_axis in row-major order, with tlast on the sixteenth.
// The last input word is registered in the product stage, then its tile's sums
// are registered into the output bank; the next tile accumulates while the bank drains.
// A last step waits in the product stage while the bank still holds an unsent
// tile, so tiles shorter than sixteen steps are paced by the draining bank.
// When the receiver stalls, the bank holds its word and input stops only
// when a new tile is ready to be stored.
// Reset clears the accumulators, the step count and all valid flags.
`timescale 1ns / 1ps

module matmul_tile_4x4_accumulator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // a_row0, a_row1, a_row2, a_row3, b_col0, b_col1, b_col2, b_col3
    input  logic [mtacc_pkg::IN_W-1:0]   s_axis_tdata,
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // tile_row, tile_col, dot_sum, zero padding
    output logic [mtacc_pkg::OUT_W-1:0]  m_axis_tdata,
    output logic                         m_axis_tlast
);
    import mtacc_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_DEPTH - 1);

    elem_t            a_el [TILE];
    elem_t            b_el [TILE];
    acc_t             lane_sum [LANES];
    logic             p1_valid_reg;
    logic             p1_last_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             in_fire;
    logic             in_last;
    logic             advance;
    logic             capture;
    logic             bank_free;

    always_comb
    begin
        for (int k = 0; k < TILE; k++)
        begin
            a_el[k] = elem_t'(s_axis_tdata[k*FIELD_W +: FIELD_W]);
            b_el[k] = elem_t'(s_axis_tdata[(TILE+k)*FIELD_W +: FIELD_W]);
        end
        advance       = p1_valid_reg && (!p1_last_reg || bank_free);
        capture       = advance && p1_last_reg;
        s_axis_tready = !p1_valid_reg || advance;
        in_fire       = s_axis_tvalid && s_axis_tready;
        in_last       = s_axis_tlast || (cnt_reg == CNT_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p1_last_reg  <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                p1_valid_reg <= 1'b1;
                p1_last_reg  <= in_last;
                cnt_reg      <= in_last ? '0 : cnt_reg + 1'b1;
            end
            else if (advance)
            begin
                p1_valid_reg <= 1'b0;
            end
        end
    end

    for (genvar r = 0; r < TILE; r++)
    begin : g_row
        for (genvar c = 0; c < TILE; c++)
        begin : g_col
            mtacc_lane u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .a     (a_el[r]),
                .b     (b_el[c]),
                .load  (in_fire),
                .accum (advance),
                .clear (p1_last_reg),
                .sum   (lane_sum[r*TILE+c])
            );
        end
    end

    mtacc_drain u_drain (
        .clk           (clk),
        .rst_n         (rst_n),
        .capture       (capture),
        .sums          (lane_sum),
        .bank_free     (bank_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
